@@ rtl/dfr_pkg.sv @@
// Package for the byte-stuffed frame receiver: framing symbols, status codes,
// register indexes and the word types of the input, result and configuration paths.
// No dependencies.
package dfr_pkg;

  // Framing symbols.
  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_ETB = 8'h17;

  // Frame geometry: two header bytes, four trailer bytes, six fixed bytes in all.
  localparam int unsigned HDR_LEN      = 2;
  localparam int unsigned TRAILER_LEN  = 4;
  localparam int unsigned FIXED_FIELDS = 6;
  // Unstuffed byte positions of the length field, high byte first.
  localparam int unsigned LEN_HI_POS   = 4;
  localparam int unsigned LEN_LO_POS   = 5;

  // Frame status codes.
  localparam logic [2:0] STATUS_PASS       = 3'd0;
  localparam logic [2:0] STATUS_BAD_FRAME  = 3'd1;
  localparam logic [2:0] STATUS_STUFFING   = 3'd2;
  localparam logic [2:0] STATUS_LENGTH     = 3'd3;
  localparam logic [2:0] STATUS_CRC        = 3'd4;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INITIAL    = 1'b1;

  // Configuration register reset values.
  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

  // One raw byte of a transfer.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_transfer;
  } rx_item_t;

  // One result word.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [2:0] frame_status;
    logic       final_block;
  } result_t;

  // CRC settings passed from the register file to the frame logic.
  typedef struct packed {
    logic [15:0] polynomial;
    logic [15:0] initial_value;
  } crc_cfg_t;

endpackage

@@ rtl/dfr_crc_step.sv @@
// Bytewise CRC-16 update, MSB first, non-reflected, programmable polynomial.
// Purely combinational; no package dependency.
module dfr_crc_step (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] polynomial,
  output logic [15:0] crc_out
);

  // Eight shift-and-reduce steps, one per data bit.
  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ polynomial;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    crc_out = acc;
  end

endmodule

@@ rtl/dfr_frame_core.sv @@
// Frame state and per-byte logic: lookahead, unstuffing, CRC, length capture
// and the end-of-frame checks. Uses dfr_pkg and dfr_crc_step.
module dfr_frame_core
  import dfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  rx_item_t in_word,
  input  crc_cfg_t crc_cfg,
  output logic     result_push,
  output result_t  result
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_PAYLD = CNT_W'(HDR_LEN + TRAILER_LEN);
  localparam logic [CNT_W-1:0] CNT_FIXED = CNT_W'(FIXED_FIELDS);

  // Frame registers.
  logic [7:0]       lookahead [4];
  logic [CNT_W-1:0] raw_count;
  logic [CNT_W-1:0] unstuffed_count;
  logic             escape_pending;
  logic             header_ok;
  logic             stuffing_error;
  logic             overlong;
  logic [15:0]      crc_register;
  logic [15:0]      length_capture;

  logic [CNT_W-1:0] raw_count_next;
  logic [CNT_W-1:0] unstuffed_count_next;
  logic             escape_pending_next;
  logic             header_ok_next;
  logic             stuffing_error_next;
  logic             overlong_next;
  logic [15:0]      crc_register_next;
  logic [15:0]      length_capture_next;

  logic        take;
  logic        emit;
  logic [7:0]  code_byte;
  logic [15:0] sent_crc;
  logic [15:0] crc_fed;
  logic [15:0] len_expect;
  logic        enough;
  logic [2:0]  status;

  dfr_crc_step u_crc (
    .crc_in     (crc_register),
    .data       (lookahead[3]),
    .polynomial (crc_cfg.polynomial),
    .crc_out    (crc_fed)
  );

  // Header tracking, unstuffing and counters.
  always_comb begin
    header_ok_next = header_ok;
    if (raw_count == '0) begin
      header_ok_next = (in_word.rx_byte == SYM_DLE);
    end else if (raw_count == CNT_W'(1)) begin
      header_ok_next = header_ok && (in_word.rx_byte == SYM_STX);
    end

    // The oldest lookahead byte is payload once header and trailer room are filled.
    take                = (raw_count >= CNT_PAYLD);
    emit                = 1'b0;
    escape_pending_next = escape_pending;
    stuffing_error_next = stuffing_error;
    if (take) begin
      if (lookahead[3] == SYM_DLE) begin
        emit                = !escape_pending;
        escape_pending_next = !escape_pending;
      end else if (escape_pending) begin
        stuffing_error_next = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    crc_register_next    = crc_register;
    length_capture_next  = length_capture;
    unstuffed_count_next = unstuffed_count;
    if (raw_count == '0) begin
      crc_register_next = crc_cfg.initial_value;
    end else if (emit) begin
      crc_register_next = crc_fed;
    end
    if (emit) begin
      if (unstuffed_count == CNT_W'(LEN_HI_POS)) begin
        length_capture_next[15:8] = lookahead[3];
      end else if (unstuffed_count == CNT_W'(LEN_LO_POS)) begin
        length_capture_next[7:0] = lookahead[3];
      end
      if (unstuffed_count < CNT_MAX) begin
        unstuffed_count_next = unstuffed_count + CNT_W'(1);
      end
    end

    raw_count_next = raw_count;
    overlong_next  = overlong;
    if (raw_count < CNT_MAX) begin
      raw_count_next = raw_count + CNT_W'(1);
    end else begin
      overlong_next = 1'b1;
    end
  end

  // End-of-frame checks, seen through the shifted lookahead.
  always_comb begin
    code_byte  = lookahead[1];
    sent_crc   = {lookahead[0], in_word.rx_byte};
    enough     = overlong_next || (raw_count_next >= CNT_PAYLD);
    len_expect = 16'(unstuffed_count_next - CNT_FIXED);
    if (!enough) begin
      status = STATUS_TOO_SHORT;
    end else if (!header_ok_next || lookahead[2] != SYM_DLE ||
                 (code_byte != SYM_ETB && code_byte != SYM_ETX)) begin
      status = STATUS_BAD_FRAME;
    end else if (stuffing_error_next || escape_pending_next) begin
      status = STATUS_STUFFING;
    end else if (unstuffed_count_next < CNT_FIXED) begin
      status = STATUS_TOO_SHORT;
    end else if (overlong_next || length_capture_next != len_expect) begin
      status = STATUS_LENGTH;
    end else if (crc_register_next != sent_crc) begin
      status = STATUS_CRC;
    end else begin
      status = STATUS_PASS;
    end
  end

  // Result word for this byte.
  always_comb begin
    result.payload_valid = emit;
    result.payload_byte  = emit ? lookahead[3] : 8'h00;
    result.frame_done    = in_word.end_of_transfer;
    result.frame_status  = in_word.end_of_transfer ? status : STATUS_PASS;
    result.final_block   = in_word.end_of_transfer && enough && (code_byte == SYM_ETX);
    result_push          = accept && (emit || in_word.end_of_transfer);
  end

  // Lookahead shift line; every byte read is overwritten before use.
  always_ff @(posedge clk) begin
    if (accept) begin
      lookahead[3] <= lookahead[2];
      lookahead[2] <= lookahead[1];
      lookahead[1] <= lookahead[0];
      lookahead[0] <= in_word.rx_byte;
    end
  end

  // Frame state; cleared at reset and after the closing byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count       <= '0;
      unstuffed_count <= '0;
      escape_pending  <= 1'b0;
      header_ok       <= 1'b0;
      stuffing_error  <= 1'b0;
      overlong        <= 1'b0;
      length_capture  <= 16'h0000;
      crc_register    <= CRC_INIT_RESET;
    end else if (accept) begin
      if (in_word.end_of_transfer) begin
        raw_count       <= '0;
        unstuffed_count <= '0;
        escape_pending  <= 1'b0;
        header_ok       <= 1'b0;
        stuffing_error  <= 1'b0;
        overlong        <= 1'b0;
        length_capture  <= 16'h0000;
        crc_register    <= crc_cfg.initial_value;
      end else begin
        raw_count       <= raw_count_next;
        unstuffed_count <= unstuffed_count_next;
        escape_pending  <= escape_pending_next;
        header_ok       <= header_ok_next;
        stuffing_error  <= stuffing_error_next;
        overlong        <= overlong_next;
        length_capture  <= length_capture_next;
        crc_register    <= crc_register_next;
      end
    end
  end

endmodule

@@ rtl/dfr_out_skid.sv @@
// Output register with a skid stage, so the input side keeps a registered ready.
// Uses dfr_pkg for the result word type.
module dfr_out_skid
  import dfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  logic    skid_valid;
  result_t skid_word;

  // Room for one more word whenever the skid stage is empty.
  assign space = !skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Data path; the skid word has priority as it is older.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_word <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

@@ rtl/dle_stuffed_frame_receiver.sv @@
// DLE/STX/ETX byte-stuffed frame receiver with CRC-16 check.
// Uses dfr_pkg, dfr_frame_core and dfr_out_skid.
//
// Usage:
//   The input channel (in_valid, in_ready, in_word) takes one raw byte of a
//   transfer per word, with end_of_transfer set on the last byte. A frame is
//   DLE STX, a payload with every DLE doubled, DLE ETB or DLE ETX, and a
//   CRC-16 high byte first. The output channel (out_valid, out_ready,
//   out_word) gives the unstuffed payload bytes, the last of which may share
//   a word with the frame close, which carries frame_status and final_block.
//   Bytes that yield neither produce no output word.
//   The CRC polynomial and start value are written through cfg_write,
//   cfg_index and cfg_data while the block is idle.
// Timing: a result word is registered into the output register (or the skid
//   stage under a stall) as its byte is accepted; a payload byte is released
//   four raw bytes after it arrives, held back by the trailer lookahead.
// Throughput: one byte per cycle while in_ready is high; the CRC update is
//   a combinational bytewise unit between the frame and output registers.
// Stalls: an output register and a one-word skid stage absorb a stall of
//   out_ready; in_ready falls once the skid stage holds a word.
// Reset: rst (synchronous) clears the frame state and both output stages and
//   restores polynomial 0x1021 and start value 0xFFFF.
module dle_stuffed_frame_receiver
  import dfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rx_item_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_word,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  crc_cfg_t crc_cfg;
  logic     accept;
  logic     result_push;
  result_t  result;
  logic     space;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_cfg.polynomial    <= CRC_POLY_RESET;
      crc_cfg.initial_value <= CRC_INIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CRC_POLYNOMIAL: crc_cfg.polynomial    <= cfg_data;
        CFG_CRC_INITIAL:    crc_cfg.initial_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign in_ready = space;
  assign accept   = in_valid && in_ready;

  dfr_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_word     (in_word),
    .crc_cfg     (crc_cfg),
    .result_push (result_push),
    .result      (result)
  );

  dfr_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (result_push),
    .push_word (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

@@ rtl/dfr_checker.sv @@
// Port-level checks on the frame receiver's result channel, and the bind
// that attaches them to the top level. Uses dfr_pkg.
module dfr_checker
  import dfr_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_word
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Every word carries a payload byte or a frame close.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.payload_valid || out_word.frame_done)
    else $error("empty result word");

  // Status and final flag are zero unless the frame closes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.frame_done |->
      out_word.frame_status == STATUS_PASS && !out_word.final_block)
    else $error("status present without frame close");

  // Payload byte is zero when not valid.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.payload_valid |-> out_word.payload_byte == 8'h00)
    else $error("payload byte set without payload_valid");

  // Only defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.frame_status <= STATUS_TOO_SHORT)
    else $error("undefined frame status");

endmodule

bind dle_stuffed_frame_receiver dfr_checker u_dfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dle_stuffed_frame_receiver: directed frames, then random
// well-formed and damaged frames under several CRC settings. Depends on dfr_pkg and the RTL.
module tb;
  import dfr_pkg::*;

  localparam int unsigned MAX_FRAME = 255;
  localparam int IDLE_PCT = 38;

  typedef enum int {
    FR_GOOD, FR_BAD_HEADER, FR_BAD_TRAILER, FR_LONE_DLE, FR_DANGLING_DLE,
    FR_BAD_LENGTH, FR_BAD_CRC, FR_TRUNCATED, FR_NOISE
  } frame_kind_e;

  // One row of the directed table: a raw byte and, where obvious, its result word.
  typedef struct packed {
    logic [7:0] rx;
    logic       eot;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t R_NONE        = '0;
  localparam result_t R_SHORT       = '{1'b0, 8'h00, 1'b1, STATUS_TOO_SHORT, 1'b0};
  localparam result_t R_SHORT_FINAL = '{1'b0, 8'h00, 1'b1, STATUS_TOO_SHORT, 1'b1};
  localparam result_t R_LONE        = '{1'b0, 8'h00, 1'b1, STATUS_STUFFING, 1'b1};
  localparam result_t R_DANGLE      = '{1'b1, SYM_DLE, 1'b1, STATUS_STUFFING, 1'b0};

  // Short transfers, an empty frame, a lone DLE and a dangling DLE.
  stim_row_t dir_rows [0:24] = '{
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_STX, 1'b0, 1'b0, R_NONE},
    '{SYM_ETX, 1'b1, 1'b1, R_SHORT},
    '{8'hFF,   1'b1, 1'b1, R_SHORT},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_STX, 1'b0, 1'b0, R_NONE},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_ETX, 1'b0, 1'b0, R_NONE},
    '{8'h00,   1'b0, 1'b0, R_NONE}, '{8'hFF,   1'b1, 1'b1, R_SHORT_FINAL},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_STX, 1'b0, 1'b0, R_NONE},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{8'h41,   1'b0, 1'b0, R_NONE},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_ETX, 1'b0, 1'b0, R_NONE},
    '{8'h00,   1'b0, 1'b0, R_NONE}, '{8'h00,   1'b1, 1'b1, R_LONE},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_STX, 1'b0, 1'b0, R_NONE},
    '{SYM_DLE, 1'b0, 1'b0, R_NONE}, '{SYM_DLE, 1'b0, 1'b0, R_NONE},
    '{SYM_ETB, 1'b0, 1'b0, R_NONE}, '{8'h00,   1'b0, 1'b0, R_NONE},
    '{8'hFF,   1'b1, 1'b1, R_DANGLE}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rx_item_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_word;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CRC_POLYNOMIAL;
  logic [15:0]          cfg_data = '0;

  // Shared between the stimulus, the receiver and the checker.
  result_t     pending_results [$];
  logic [7:0]  tx_bytes [$];
  int          n_errors = 0;
  int          idle_pct = IDLE_PCT;
  bit          hold_req = 1'b0;
  bit          word_typed = 1'b0;
  result_t     word_want = '0;

  // Predictor state: CRC settings and the frame being received.
  logic [15:0] m_poly, m_init, m_crc, m_len;
  logic [7:0]  m_look [4];
  int unsigned m_raw, m_unst;
  bit          m_esc, m_hdr, m_stuf, m_over;

  dle_stuffed_frame_receiver #(.MAX_FRAME_BYTES(MAX_FRAME)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Bytewise MSB-first CRC-16 update with no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b,
                                             input logic [15:0] poly);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ poly) : (r << 1);
    return r;
  endfunction

  function automatic void frame_clear();
    foreach (m_look[i]) m_look[i] = 8'h00;
    m_raw  = 0;
    m_unst = 0;
    m_esc  = 1'b0;
    m_hdr  = 1'b0;
    m_stuf = 1'b0;
    m_crc  = m_init;
    m_len  = '0;
    m_over = 1'b0;
  endfunction

  // Advances the predicted frame by one raw byte; returns 1 when a result word is due.
  function automatic bit unstuff_and_check(input rx_item_t w, output result_t r);
    logic [7:0]  old, code;
    logic [15:0] sent;
    int unsigned n;
    bit          emit, enough;
    r    = '0;
    n    = m_raw;
    emit = 1'b0;
    if (n == 0) begin
      m_crc = m_init;
      m_hdr = (w.rx_byte == SYM_DLE);
    end else if (n == 1) begin
      m_hdr = m_hdr && (w.rx_byte == SYM_STX);
    end
    // The byte leaving the lookahead is payload: undo the DLE doubling.
    if (n >= HDR_LEN + TRAILER_LEN) begin
      old = m_look[3];
      if (old == SYM_DLE) begin
        if (!m_esc) begin
          emit  = 1'b1;
          m_esc = 1'b1;
        end else begin
          m_esc = 1'b0;
        end
      end else if (m_esc) begin
        m_stuf = 1'b1;
      end else begin
        emit = 1'b1;
      end
      if (emit) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = old;
        m_crc = crc16_byte(m_crc, old, m_poly);
        if (m_unst == LEN_HI_POS) m_len[15:8] = old;
        else if (m_unst == LEN_LO_POS) m_len[7:0] = old;
        if (m_unst < MAX_FRAME) m_unst++;
      end
    end
    m_look[3] = m_look[2];
    m_look[2] = m_look[1];
    m_look[1] = m_look[0];
    m_look[0] = w.rx_byte;
    if (m_raw < MAX_FRAME) m_raw++;
    else m_over = 1'b1;
    // Close the frame, checks in order of priority.
    if (w.end_of_transfer) begin
      code   = m_look[2];
      sent   = {m_look[1], m_look[0]};
      enough = m_over || (m_raw >= HDR_LEN + TRAILER_LEN);
      r.frame_done = 1'b1;
      if (!enough)
        r.frame_status = STATUS_TOO_SHORT;
      else if (!m_hdr || m_look[3] != SYM_DLE || (code != SYM_ETB && code != SYM_ETX))
        r.frame_status = STATUS_BAD_FRAME;
      else if (m_stuf || m_esc)
        r.frame_status = STATUS_STUFFING;
      else if (m_unst < FIXED_FIELDS)
        r.frame_status = STATUS_TOO_SHORT;
      else if (m_over || m_len != 16'(m_unst - FIXED_FIELDS))
        r.frame_status = STATUS_LENGTH;
      else if (m_crc != sent)
        r.frame_status = STATUS_CRC;
      r.final_block = enough && (code == SYM_ETX);
      frame_clear();
    end
    return r.payload_valid || r.frame_done;
  endfunction

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    n_errors++;
  endtask

  // Predict on every accepted input word, check every accepted result word.
  always @(posedge clk) begin
    result_t r, e;
    if (rst) begin
      m_poly = CRC_POLY_RESET;
      m_init = CRC_INIT_RESET;
      frame_clear();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CRC_POLYNOMIAL: m_poly = cfg_data;
          CFG_CRC_INITIAL:    m_init = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (unstuff_and_check(in_word, r) && !word_typed) pending_results.push_back(r);
        if (word_typed) pending_results.push_back(word_want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result word with none expected, actual %h", $time, out_word);
          n_errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_word.payload_valid !== e.payload_valid)
            report_field("payload_valid", e.payload_valid, out_word.payload_valid);
          if (out_word.payload_byte !== e.payload_byte)
            report_field("payload_byte", e.payload_byte, out_word.payload_byte);
          if (out_word.frame_done !== e.frame_done)
            report_field("frame_done", e.frame_done, out_word.frame_done);
          if (out_word.frame_status !== e.frame_status)
            report_field("frame_status", e.frame_status, out_word.frame_status);
          if (out_word.final_block !== e.final_block)
            report_field("final_block", e.final_block, out_word.final_block);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 60;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offers one raw byte after a random gap and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                           input result_t want);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    word_typed = typed;
    word_want  = want;
    in_valid  <= 1'b1;
    in_word   <= '{rx_byte: b, end_of_transfer: eot};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering words and waits until every expected result word has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Builds the raw bytes of one transfer: a stuffed frame, possibly damaged on purpose.
  task automatic make_frame(input frame_kind_e kind, input int plen, input logic [15:0] poly,
                            input logic [15:0] init);
    logic [7:0]  pl [$];
    logic [7:0]  b;
    logic [15:0] c;
    int          pos;
    pl.delete();
    tx_bytes.delete();
    for (int i = 0; i < plen; i++) begin
      b = ($urandom_range(4) == 0) ? SYM_DLE : 8'($urandom);
      pl.push_back(b);
    end
    if (plen >= FIXED_FIELDS) begin
      pl[LEN_HI_POS] = 8'((plen - FIXED_FIELDS) >> 8);
      pl[LEN_LO_POS] = 8'(plen - FIXED_FIELDS);
      if (kind == FR_BAD_LENGTH) pl[LEN_LO_POS] ^= 8'(1 << $urandom_range(7));
    end
    c = init;
    foreach (pl[i]) c = crc16_byte(c, pl[i], poly);
    if (kind == FR_BAD_CRC) c ^= 16'(1 << $urandom_range(15));
    tx_bytes = {SYM_DLE, SYM_STX};
    if (kind == FR_BAD_HEADER) tx_bytes[$urandom_range(1)] = 8'($urandom);
    foreach (pl[i]) begin
      tx_bytes.push_back(pl[i]);
      if (pl[i] == SYM_DLE) tx_bytes.push_back(SYM_DLE);
    end
    // A DLE followed by anything but DLE, somewhere in the payload.
    if (kind == FR_LONE_DLE) begin
      pos = $urandom_range(HDR_LEN, tx_bytes.size());
      b   = 8'($urandom);
      tx_bytes.insert(pos, (b == SYM_DLE) ? 8'h5A : b);
      tx_bytes.insert(pos, SYM_DLE);
    end
    if (kind == FR_DANGLING_DLE) tx_bytes.push_back(SYM_DLE);
    tx_bytes.push_back(SYM_DLE);
    tx_bytes.push_back($urandom_range(1) ? SYM_ETX : SYM_ETB);
    tx_bytes.push_back(c[15:8]);
    tx_bytes.push_back(c[7:0]);
    if (kind == FR_BAD_TRAILER)
      tx_bytes[tx_bytes.size() - 4 + $urandom_range(1)] = 8'($urandom);
    if (kind == FR_TRUNCATED) begin
      pos = $urandom_range(1, tx_bytes.size() - 1);
      while (tx_bytes.size() > pos) void'(tx_bytes.pop_back());
    end
    if (kind == FR_NOISE) begin
      tx_bytes.delete();
      repeat ($urandom_range(1, 12))
        tx_bytes.push_back(($urandom_range(3) == 0) ? SYM_DLE : 8'($urandom));
    end
  endtask

  // Main sequence: reset, the directed table, then random phases with new CRC settings.
  initial begin
    logic [15:0] poly, init;
    int          phase_bytes, pick, plen;
    frame_kind_e kind;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].rx, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    for (int ph = 1; ph <= 5; ph++) begin
      case (ph)
        1: begin poly = 16'h1021; init = 16'hFFFF; end
        2: begin poly = 16'hFFFF; init = 16'h0000; end
        3: begin poly = 16'h0000; init = 16'hFFFF; end
        4: begin poly = 16'h8005; init = 16'($urandom); end
        default: begin poly = 16'($urandom); init = 16'($urandom); end
      endcase
      write_reg(CFG_CRC_POLYNOMIAL, poly);
      write_reg(CFG_CRC_INITIAL, init);
      // Phase three runs with no idling on either side.
      idle_pct = (ph == 3) ? 0 : IDLE_PCT;
      phase_bytes = 0;
      // One frame longer than the raw count can hold.
      if (ph == 2) begin
        make_frame(FR_GOOD, 250, poly, init);
        foreach (tx_bytes[i])
          send_byte(tx_bytes[i], i == tx_bytes.size() - 1, 1'b0, R_NONE);
      end
      while (phase_bytes < 20) begin
        pick = $urandom_range(99);
        if (pick < 55) kind = FR_GOOD;
        else kind = frame_kind_e'(1 + (pick - 55) % 8);
        pick = $urandom_range(9);
        if (pick == 0) plen = $urandom_range(0, FIXED_FIELDS - 1);
        else if (pick == 1) plen = $urandom_range(25, 60);
        else plen = $urandom_range(FIXED_FIELDS, 20);
        make_frame(kind, plen, poly, init);
        foreach (tx_bytes[i]) begin
          send_byte(tx_bytes[i], i == tx_bytes.size() - 1, 1'b0, R_NONE);
          phase_bytes++;
          if (ph == 1 && phase_bytes == 10) hold_req = 1'b1;
        end
      end
      drain_results();
    end

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
